@@ rtl/core/button_click_classifier_top_assert.svh @@
// Assertion macros for the button click classifier.
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BCC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("button click classifier: same-cycle check failed");
`define BCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("button click classifier: next-cycle check failed");
`else
`define BCC_ASSERT_NOW(label, ante, cons)
`define BCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/bcc_pkg.sv @@
// Package with the types and codes of the button click classifier.
package bcc_pkg;

	localparam int unsigned CFG_W = 16;
	localparam int unsigned TS_W  = 32;

	localparam logic CFG_IDX_HOLD   = 1'b0;
	localparam logic CFG_IDX_WINDOW = 1'b1;

	localparam logic [CFG_W-1:0] HOLD_RESET   = 16'd1000;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd300;

	localparam logic [1:0] PH_WAIT_PRESS   = 2'd0;
	localparam logic [1:0] PH_WAIT_RELEASE = 2'd1;
	localparam logic [1:0] PH_CHECK_DOUBLE = 2'd2;
	localparam logic [1:0] PH_IDLE         = 2'd3;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_CLICK  = 2'd1;
	localparam logic [1:0] EV_DOUBLE = 2'd2;
	localparam logic [1:0] EV_HOLD   = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] hold_time_ms;
		logic [CFG_W-1:0] double_click_window_ms;
	} bcc_cfg_t;

endpackage

@@ rtl/core/bcc_if.sv @@
// Request channel interfaces for polls and for classified events.
interface bcc_in_if;
	logic        valid;
	logic        ready;
	logic        button_pressed;
	logic [31:0] now_ms;

	modport source (output valid, output button_pressed, output now_ms, input ready);
	modport sink (input valid, input button_pressed, input now_ms, output ready);
endinterface

interface bcc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;

	modport source (output valid, output event_code, input ready);
	modport sink (input valid, input event_code, output ready);
endinterface

@@ rtl/core/bcc_classifier.sv @@
// Four-phase click classifier state and next-event logic for one poll.
module bcc_classifier (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   pressed,
	input  logic [31:0]            now_ms,
	input  bcc_pkg::bcc_cfg_t      cfg,
	output logic [1:0]             event_code
);
	import bcc_pkg::*;

	logic [1:0]      phase_q;
	logic [1:0]      phase_d;
	logic [TS_W-1:0] press_ts_q;
	logic [TS_W-1:0] elapsed;
	logic            hold_hit;
	logic            window_hit;

	assign elapsed    = now_ms - press_ts_q;
	assign hold_hit   = elapsed >= {{(TS_W-CFG_W){1'b0}}, cfg.hold_time_ms};
	assign window_hit = elapsed >= {{(TS_W-CFG_W){1'b0}}, cfg.double_click_window_ms};

	always_comb begin
		phase_d    = phase_q;
		event_code = EV_NONE;
		case (phase_q)
			PH_WAIT_PRESS: begin
				if (pressed) begin
					phase_d = PH_WAIT_RELEASE;
				end
			end
			PH_WAIT_RELEASE: begin
				if (hold_hit) begin
					phase_d    = PH_IDLE;
					event_code = EV_HOLD;
				end else if (!pressed) begin
					phase_d = PH_CHECK_DOUBLE;
				end
			end
			PH_CHECK_DOUBLE: begin
				if (pressed) begin
					phase_d    = PH_IDLE;
					event_code = EV_DOUBLE;
				end else if (window_hit) begin
					phase_d    = PH_WAIT_PRESS;
					event_code = EV_CLICK;
				end
			end
			default: begin
				if (!pressed) begin
					phase_d = PH_WAIT_PRESS;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT_PRESS;
			press_ts_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (phase_q == PH_WAIT_PRESS && pressed) begin
				press_ts_q <= now_ms;
			end
		end
	end
endmodule

@@ rtl/core/button_click_classifier_top.sv @@
// Top level of the button click classifier with input, result and configuration registers.
// Each poll request gives exactly one event request, moved from the input register to the result
// register when the output side is free; a new poll can be taken every cycle unless the output
// side stalls. The path from the poll register to the event register holds one 32-bit subtraction,
// two compares and the phase update. Configuration writes take effect at the next clock edge.
module button_click_classifier_top (
	input  logic                   clk,
	input  logic                   arst_n,
	bcc_in_if.sink                 in_req,
	bcc_out_if.source              out_req,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [15:0]            cfg_wdata
);
	import bcc_pkg::*;

	`include "button_click_classifier_top_assert.svh"

	bcc_cfg_t        cfg_q;
	logic            valid_s1;
	logic            pressed_s1;
	logic [TS_W-1:0] now_s1;
	logic            out_valid_q;
	logic [1:0]      event_q;
	logic [1:0]      event_d;
	logic            out_free;
	logic            advance;

	assign out_free     = !out_valid_q || out_req.ready;
	assign advance      = valid_s1 && out_free;
	assign in_req.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_time_ms           <= HOLD_RESET;
			cfg_q.double_click_window_ms <= WINDOW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_HOLD:   cfg_q.hold_time_ms           <= cfg_wdata;
				CFG_IDX_WINDOW: cfg_q.double_click_window_ms <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_req.ready) begin
			valid_s1 <= in_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_req.valid && in_req.ready) begin
			pressed_s1 <= in_req.button_pressed;
			now_s1     <= in_req.now_ms;
		end
	end

	bcc_classifier u_classifier (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.pressed    (pressed_s1),
		.now_ms     (now_s1),
		.cfg        (cfg_q),
		.event_code (event_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= event_d;
		end
	end

	assign out_req.valid      = out_valid_q;
	assign out_req.event_code = event_q;

	`BCC_ASSERT_NOW(a_stall_blocks_input, valid_s1 && out_valid_q && !out_req.ready, !in_req.ready)
	`BCC_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_q)
	`BCC_ASSERT_NOW(a_not_ready_means_busy, !in_req.ready, valid_s1 && out_valid_q)
endmodule

@@ sim/button_click_classifier_top_tb.sv @@
// Self-checking testbench that drives button polls into the classifier and checks every event.
module button_click_classifier_top_tb;
	import bcc_pkg::*;

	localparam int CLK_PERIOD       = 12;
	localparam int RESET_CYCLES     = 6;
	localparam int SETTLE_CYCLES    = 12;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LIMIT_CYCLES     = 400000;
	localparam int MAX_REPORTS      = 10;

	localparam logic [CFG_W-1:0] HOLD_AT_RESET   = 16'd1000;
	localparam logic [CFG_W-1:0] WINDOW_AT_RESET = 16'd300;

	typedef struct packed {
		logic            pressed;
		logic [TS_W-1:0] now;
	} poll_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             cfg_we = 1'b0;
	logic             cfg_index = CFG_IDX_HOLD;
	logic [CFG_W-1:0] cfg_wdata = '0;

	logic            poll_valid = 1'b0;
	logic            poll_pressed = 1'b0;
	logic [TS_W-1:0] poll_now = '0;
	logic            event_ready = 1'b0;

	bcc_in_if in_req ();
	bcc_out_if out_req ();

	assign in_req.valid          = poll_valid;
	assign in_req.button_pressed = poll_pressed;
	assign in_req.now_ms         = poll_now;
	assign out_req.ready         = event_ready;

	button_click_classifier_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_req    (in_req),
		.out_req   (out_req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	poll_t      poll_pending[$];
	logic [1:0] awaited_events[$];
	poll_t      next_poll;
	logic [1:0] want_event;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_off_arm = 1'b0;
	logic        recv_blocked = 1'b0;
	int unsigned fail_count = 0;
	int unsigned polls_added = 0;
	logic [TS_W-1:0] stim_ms = '0;

	logic [1:0]       pr_phase = PH_WAIT_PRESS;
	logic [TS_W-1:0]  pr_press_ms = '0;
	logic [CFG_W-1:0] pr_hold = HOLD_AT_RESET;
	logic [CFG_W-1:0] pr_window = WINDOW_AT_RESET;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [1:0] classify_poll(input logic pressed, input logic [TS_W-1:0] now);
		logic [TS_W-1:0] elapsed;
		logic [1:0]      ev;
		elapsed = now - pr_press_ms;
		ev = EV_NONE;
		case (pr_phase)
			PH_WAIT_PRESS: begin
				if (pressed) begin
					pr_press_ms = now;
					pr_phase = PH_WAIT_RELEASE;
				end
			end
			PH_WAIT_RELEASE: begin
				if (!pressed) begin
					pr_phase = PH_CHECK_DOUBLE;
				end
				// A hold overrides a release seen in the same poll.
				if (elapsed >= TS_W'(pr_hold)) begin
					pr_phase = PH_IDLE;
					ev = EV_HOLD;
				end
			end
			PH_CHECK_DOUBLE: begin
				// The second press is tested before the window runs out.
				if (pressed) begin
					pr_phase = PH_IDLE;
					ev = EV_DOUBLE;
				end else if (elapsed >= TS_W'(pr_window)) begin
					pr_phase = PH_WAIT_PRESS;
					ev = EV_CLICK;
				end
			end
			default: begin
				if (!pressed) begin
					pr_phase = PH_WAIT_PRESS;
				end
			end
		endcase
		return ev;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_valid <= 1'b0;
			poll_pressed <= 1'b0;
			poll_now <= '0;
		end else begin
			if (in_req.valid && in_req.ready) begin
				awaited_events.push_back(classify_poll(in_req.button_pressed, in_req.now_ms));
			end
			if (!poll_valid || in_req.ready) begin
				if (poll_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_poll = poll_pending.pop_front();
					poll_valid <= 1'b1;
					poll_pressed <= next_poll.pressed;
					poll_now <= next_poll.now;
				end else begin
					poll_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_ready <= 1'b0;
		end else begin
			if (out_req.valid && event_ready) begin
				if (awaited_events.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("%0t: event %0d arrived with no poll waiting for it",
							$time, out_req.event_code);
					end
				end else begin
					want_event = awaited_events.pop_front();
					if (out_req.event_code !== want_event) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("%0t: event_code mismatch: expected %0d, got %0d",
								$time, want_event, out_req.event_code);
						end
					end
				end
			end
			event_ready <= !recv_blocked && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin : receiver_hold_off
		wait (hold_off_arm);
		@(posedge clk);
		recv_blocked <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		recv_blocked <= 1'b0;
	end

	task automatic add_poll(input logic pressed, input logic [TS_W-1:0] now);
		poll_t p;
		p.pressed = pressed;
		p.now = now;
		poll_pending.push_back(p);
		polls_added++;
	endtask

	// One press gesture with random timing around the thresholds, or a burst of noise.
	task automatic add_gesture();
		int unsigned scale;
		int unsigned step_max;
		int unsigned runs;
		logic        level;
		scale = $urandom_range(1) ? 32'(pr_hold) : 32'(pr_window);
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				stim_ms = $urandom();
				add_poll(1'($urandom_range(1)), stim_ms);
			end
		end else begin
			if ($urandom_range(15) == 0) begin
				stim_ms = 32'hFFFF_FFFF - $urandom_range(2 * scale);
			end
			step_max = scale * $urandom_range(1, 6) / 4 + 1;
			runs = 2 * $urandom_range(1, 2);
			level = 1'b1;
			repeat (runs) begin
				repeat ($urandom_range(1, 4)) begin
					stim_ms += $urandom_range(step_max);
					add_poll(level, stim_ms);
				end
				level = !level;
			end
			repeat ($urandom_range(0, 3)) begin
				stim_ms += $urandom_range(2 * scale);
				add_poll(1'b0, stim_ms);
			end
		end
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDX_HOLD) begin
			pr_hold = value;
		end else begin
			pr_window = value;
		end
	endtask

	task automatic wait_drained();
		while (poll_pending.size() != 0 || poll_valid || awaited_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] window,
		input int unsigned send_pct, input int unsigned recv_pct,
		input int unsigned n_polls, input bit squeeze);
		write_reg(CFG_IDX_HOLD, hold);
		write_reg(CFG_IDX_WINDOW, window);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		polls_added = 0;
		while (polls_added < n_polls) begin
			add_gesture();
		end
		if (squeeze) begin
			hold_off_arm = 1'b1;
		end
		wait_drained();
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_poll(1'b0, 32'd0);
		add_poll(1'b1, 32'd100);
		add_poll(1'b1, 32'd500);
		add_poll(1'b0, 32'd600);
		add_poll(1'b0, 32'd700);
		add_poll(1'b1, 32'd1000);
		add_poll(1'b0, 32'd1100);
		add_poll(1'b1, 32'd1150);
		add_poll(1'b0, 32'd1200);
		add_poll(1'b1, 32'd2000);
		add_poll(1'b1, 32'd3000);
		add_poll(1'b0, 32'd3600);
		// Release in the same poll that reaches the hold time.
		add_poll(1'b1, 32'd4000);
		add_poll(1'b0, 32'd5000);
		add_poll(1'b0, 32'd5001);
		// Second press arriving after the window has passed.
		add_poll(1'b1, 32'd6000);
		add_poll(1'b0, 32'd6010);
		add_poll(1'b1, 32'd6400);
		add_poll(1'b0, 32'd6401);
		// Press time just below the timestamp wrap.
		add_poll(1'b1, 32'hFFFF_FF00);
		add_poll(1'b0, 32'h0000_0010);
		add_poll(1'b0, 32'h0000_0030);
		wait_drained();

		write_reg(CFG_IDX_HOLD, 16'd0);
		write_reg(CFG_IDX_WINDOW, 16'd0);
		add_poll(1'b1, 32'hFFFF_FFFF);
		add_poll(1'b1, 32'hFFFF_FFFF);
		add_poll(1'b0, 32'd0);
		wait_drained();
		write_reg(CFG_IDX_HOLD, 16'hFFFF);
		add_poll(1'b1, 32'd50);
		add_poll(1'b0, 32'd50);
		add_poll(1'b0, 32'd50);
		wait_drained();

		run_phase(16'd40, 16'd25, 0, 0, 300, 1'b0);
		run_phase(16'd1, 16'd1, 81, 0, 250, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 0, 81, 250, 1'b0);
		run_phase(16'd200, 16'd500, 14, 14, 300, 1'b0);
		run_phase(16'd60, 16'd20, 0, 0, 300, 1'b1);
		run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 14, 14, 250,
			1'b0);
		run_phase(16'd9, 16'd120, 0, 0, 250, 1'b0);

		if (fail_count == 0 && awaited_events.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : run_limit
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bcc_pkg.sv
rtl/core/bcc_if.sv
rtl/core/bcc_classifier.sv
rtl/core/button_click_classifier_top.sv
sim/button_click_classifier_top_tb.sv
